FILE: rtl/csc_pkg.sv
// Shared constants, types and the cosine weight table of the image scaler.
package csc_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_DIM    = 4096;
  localparam int WTB            = 10;
  localparam int ROM_SIZE       = 1 << WTB;
  localparam int ROM_HALF       = ROM_SIZE / 2;
  localparam int QBITS          = 24;
  localparam int DIV_STAGES     = QBITS;
  localparam int FIFO_DEPTH     = 32;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic        vld;
    logic        ld;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [31:0] rgba;
    logic [11:0] dx;
    logic [11:0] dy;
  } item_t;

  typedef struct packed {
    logic        ovf;
    logic [13:0] rem;
    logic [23:0] dvd;
    logic [23:0] q;
  } div_t;

  typedef struct packed {
    logic [7:0]  n0;
    logic [7:0]  n1;
    logic [16:0] w;
  } axis_t;

  typedef logic [16:0] wrom_t [ROM_SIZE];

  // Shift-and-subtract quotient, only evaluated while the weight table is built.
  function automatic longint unsigned const_udiv(input longint unsigned n,
                                                 input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic wrom_t build_wrom();
    wrom_t            t;
    longint unsigned  j;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  term;
    longint           c;
    longint           w;
    for (int i = 0; i < ROM_SIZE; i++) begin
      j    = (i > ROM_HALF) ? longint'(ROM_SIZE - i) : longint'(i);
      x    = (64'd3373259426 * j) >> WTB;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      c    = 64'sd1 << 30;
      for (int k = 1; k <= 8; k++) begin
        term = const_udiv((term * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
        if (k[0]) c = c - longint'(term);
        else c = c + longint'(term);
      end
      if (i > ROM_HALF) c = -c;
      w = ((64'sd1 << 30) - c + (64'sd1 << 14)) >>> 15;
      if (w < 0) w = 0;
      if (w > 65536) w = 65536;
      t[i] = 17'(w);
    end
    return t;
  endfunction

  localparam wrom_t WROM = build_wrom();

endpackage

FILE: rtl/cosine_image_scaler.sv
// Cosine image scaler: frame store, coordinate divider pipeline, blend and result queue.
//
//  Channel  Direction  Handshake          Payload
//  in_      in         in_valid/in_ready  req_type, src_x, src_y, pixel_rgba, dst_x, dst_y
//  out_     out        out_valid/ready    out_rgba, out_x, out_y
//  cfg_     APB write  psel&penable       four size registers at byte addresses 0, 4, 8, 12
//
// A load does not hold the input off; a compute holds it off in the cycle after it, as its
// four neighbours come from the two read ports of the frame store, the upper row first and
// the lower row next. Results leave through a 32-entry result queue. Input stalls while 32
// results are outstanding. Reset is synchronous; the frame store is not cleared.
module cosine_image_scaler
  import csc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_src_x,
  input  logic [7:0]  in_src_y,
  input  logic [31:0] in_pixel_rgba,
  input  logic [11:0] in_dst_x,
  input  logic [11:0] in_dst_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_rgba,
  output logic [11:0] out_x,
  output logic [11:0] out_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]  src_width_r, src_height_r;
  logic [12:0] dst_width_r, dst_height_r;

  logic        bubble_r, bubble_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        in_acc, cmp_acc, out_acc;

  item_t       it_r [DIV_STAGES+1];
  div_t        dvx_r [DIV_STAGES+1];
  div_t        dvy_r [DIV_STAGES+1];
  item_t       mp_r, m1_r, m2_r, bl_r;
  axis_t       ax_r, ay_r, ax1_r, ay1_r, ax2_r, ay2_r;
  logic [16:0] wy2_r;
  logic [31:0] p00_r, p01_r;
  logic [24:0] top_r [4];
  logic [24:0] bot_r [4];

  logic [31:0] fs_mem [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
  logic [31:0] rd_a_r, rd_b_r;
  logic [15:0] ra_addr, rb_addr;

  logic [55:0] fifo_mem [FIFO_DEPTH];
  logic [4:0]  wr_ptr_r, rd_ptr_r;
  logic [5:0]  fcnt_r;
  logic        fifo_wr;
  logic [31:0] res_rgba;

  logic [8:0]  sw_eff, sh_eff;
  logic [12:0] tw_eff, th_eff;
  logic [13:0] den_x, den_y;
  logic [21:0] num_x, num_y;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 9'd256;
      src_height_r <= 9'd256;
      dst_width_r  <= 13'd256;
      dst_height_r <= 13'd256;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_SRC_WIDTH:  src_width_r  <= pwdata[8:0];
        REG_SRC_HEIGHT: src_height_r <= pwdata[8:0];
        REG_DST_WIDTH:  dst_width_r  <= pwdata[12:0];
        REG_DST_HEIGHT: dst_height_r <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SRC_WIDTH:  prdata = 32'(src_width_r);
      REG_SRC_HEIGHT: prdata = 32'(src_height_r);
      REG_DST_WIDTH:  prdata = 32'(dst_width_r);
      REG_DST_HEIGHT: prdata = 32'(dst_height_r);
      default:        prdata = '0;
    endcase
  end

  // Sizes as used: zero counts as one, larger values saturate.
  assign sw_eff = (src_width_r == '0) ? 9'd1 :
                  ((src_width_r > 9'(MAX_SRC_WIDTH)) ? 9'(MAX_SRC_WIDTH) : src_width_r);
  assign sh_eff = (src_height_r == '0) ? 9'd1 :
                  ((src_height_r > 9'(MAX_SRC_HEIGHT)) ? 9'(MAX_SRC_HEIGHT) : src_height_r);
  assign tw_eff = (dst_width_r == '0) ? 13'd1 :
                  ((dst_width_r > 13'(MAX_DST_DIM)) ? 13'(MAX_DST_DIM) : dst_width_r);
  assign th_eff = (dst_height_r == '0) ? 13'd1 :
                  ((dst_height_r > 13'(MAX_DST_DIM)) ? 13'(MAX_DST_DIM) : dst_height_r);
  assign den_x  = {tw_eff, 1'b0};
  assign den_y  = {th_eff, 1'b0};

  // The numerator is offset by one denominator so that it is never negative; the
  // integer part of the quotient is then the base index plus one.
  assign num_x = 22'({in_dst_x, 1'b1}) * 22'(sw_eff) + 22'(tw_eff);
  assign num_y = 22'({in_dst_y, 1'b1}) * 22'(sh_eff) + 22'(th_eff);

  // Input handshake
  assign in_ready = !bubble_r && (cnt_r < 6'(FIFO_DEPTH));
  assign in_acc   = in_valid && in_ready;
  assign cmp_acc  = in_acc && in_req_type;
  assign out_acc  = out_valid && out_ready;

  assign bubble_nxt = cmp_acc;
  assign cnt_nxt    = cnt_r + 6'(cmp_acc) - 6'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bubble_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      bubble_r <= bubble_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  function automatic div_t div_init(input logic [21:0] num, input logic [13:0] den);
    div_t d;
    d.ovf = (num >= {den, 8'b0});
    d.rem = num[21:8];
    d.dvd = {num[7:0], 16'b0};
    d.q   = '0;
    return d;
  endfunction

  function automatic div_t div_step(input div_t d, input logic [13:0] den);
    div_t        n;
    logic [14:0] t;
    t     = {d.rem, d.dvd[23]};
    n     = d;
    n.dvd = {d.dvd[22:0], 1'b0};
    if (t >= {1'b0, den}) begin
      n.rem = 14'(t - {1'b0, den});
      n.q   = {d.q[22:0], 1'b1};
    end else begin
      n.rem = t[13:0];
      n.q   = {d.q[22:0], 1'b0};
    end
    return n;
  endfunction

  function automatic axis_t map_axis(input div_t d, input logic [8:0] s);
    axis_t      a;
    logic [7:0] idx;
    logic [7:0] smax;
    idx  = d.q[23:16];
    smax = 8'(s - 9'd1);
    a.w  = WROM[d.q[15:16-WTB]];
    if (d.ovf) begin
      a.n0 = smax;
      a.n1 = smax;
    end else begin
      a.n1 = (idx > smax) ? smax : idx;
      if (idx == '0) a.n0 = '0;
      else a.n0 = ((idx - 8'd1) > smax) ? smax : (idx - 8'd1);
    end
    return a;
  endfunction

  // Divider pipeline: one quotient bit per stage for both axes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STAGES; i++) it_r[i].vld <= 1'b0;
    end else begin
      it_r[0].vld <= in_acc;
      for (int i = 1; i <= DIV_STAGES; i++) it_r[i].vld <= it_r[i-1].vld;
    end
    it_r[0].ld   <= !in_req_type;
    it_r[0].sx   <= in_src_x;
    it_r[0].sy   <= in_src_y;
    it_r[0].rgba <= in_pixel_rgba;
    it_r[0].dx   <= in_dst_x;
    it_r[0].dy   <= in_dst_y;
    dvx_r[0]     <= div_init(num_x, den_x);
    dvy_r[0]     <= div_init(num_y, den_y);
    for (int i = 1; i <= DIV_STAGES; i++) begin
      it_r[i].ld   <= it_r[i-1].ld;
      it_r[i].sx   <= it_r[i-1].sx;
      it_r[i].sy   <= it_r[i-1].sy;
      it_r[i].rgba <= it_r[i-1].rgba;
      it_r[i].dx   <= it_r[i-1].dx;
      it_r[i].dy   <= it_r[i-1].dy;
      dvx_r[i]     <= div_step(dvx_r[i-1], den_x);
      dvy_r[i]     <= div_step(dvy_r[i-1], den_y);
    end
  end

  // Neighbour mapping, frame store access for the upper and lower rows, blend.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r.vld <= 1'b0;
      m1_r.vld <= 1'b0;
      m2_r.vld <= 1'b0;
      bl_r.vld <= 1'b0;
    end else begin
      mp_r.vld <= it_r[DIV_STAGES].vld;
      m1_r.vld <= mp_r.vld && !mp_r.ld;
      m2_r.vld <= m1_r.vld;
      bl_r.vld <= m2_r.vld;
    end
    mp_r.ld   <= it_r[DIV_STAGES].ld;
    mp_r.sx   <= it_r[DIV_STAGES].sx;
    mp_r.sy   <= it_r[DIV_STAGES].sy;
    mp_r.rgba <= it_r[DIV_STAGES].rgba;
    mp_r.dx   <= it_r[DIV_STAGES].dx;
    mp_r.dy   <= it_r[DIV_STAGES].dy;
    ax_r      <= map_axis(dvx_r[DIV_STAGES], sw_eff);
    ay_r      <= map_axis(dvy_r[DIV_STAGES], sh_eff);
    m1_r.ld   <= mp_r.ld;
    m1_r.sx   <= mp_r.sx;
    m1_r.sy   <= mp_r.sy;
    m1_r.rgba <= mp_r.rgba;
    m1_r.dx   <= mp_r.dx;
    m1_r.dy   <= mp_r.dy;
    ax1_r     <= ax_r;
    ay1_r     <= ay_r;
    m2_r.ld   <= m1_r.ld;
    m2_r.sx   <= m1_r.sx;
    m2_r.sy   <= m1_r.sy;
    m2_r.rgba <= m1_r.rgba;
    m2_r.dx   <= m1_r.dx;
    m2_r.dy   <= m1_r.dy;
    ax2_r     <= ax1_r;
    ay2_r     <= ay1_r;
    p00_r     <= rd_a_r;
    p01_r     <= rd_b_r;
    bl_r.ld   <= m2_r.ld;
    bl_r.sx   <= m2_r.sx;
    bl_r.sy   <= m2_r.sy;
    bl_r.rgba <= m2_r.rgba;
    bl_r.dx   <= m2_r.dx;
    bl_r.dy   <= m2_r.dy;
    wy2_r     <= ay2_r.w;
    for (int c = 0; c < 4; c++) begin
      top_r[c] <= 25'(p00_r[8*c +: 8]) * 25'(17'h10000 - ax2_r.w)
                + 25'(p01_r[8*c +: 8]) * 25'(ax2_r.w);
      bot_r[c] <= 25'(rd_a_r[8*c +: 8]) * 25'(17'h10000 - ax2_r.w)
                + 25'(rd_b_r[8*c +: 8]) * 25'(ax2_r.w);
    end
  end

  // A compute reads the upper row in its first cycle and the lower row in the next,
  // which is always free because the input takes no item in the cycle after a compute.
  always_comb begin
    if (mp_r.vld && !mp_r.ld) begin
      ra_addr = {ay_r.n0, ax_r.n0};
      rb_addr = {ay_r.n0, ax_r.n1};
    end else begin
      ra_addr = {ay1_r.n1, ax1_r.n0};
      rb_addr = {ay1_r.n1, ax1_r.n1};
    end
  end

  // Loads are written at the same stage as reads, which keeps accesses in transfer order.
  always_ff @(posedge clk) begin
    if (mp_r.vld && mp_r.ld) fs_mem[{mp_r.sy, mp_r.sx}] <= mp_r.rgba;
    rd_a_r <= fs_mem[ra_addr];
    rd_b_r <= fs_mem[rb_addr];
  end

  always_comb begin
    logic [41:0] sum;
    for (int c = 0; c < 4; c++) begin
      sum = 42'(top_r[c]) * 42'(17'h10000 - wy2_r) + 42'(bot_r[c]) * 42'(wy2_r)
          + 42'h0080000000;
      res_rgba[8*c +: 8] = (sum[41:32] > 10'd255) ? 8'hFF : sum[39:32];
    end
  end

  // Result queue
  assign fifo_wr   = bl_r.vld;
  assign out_valid = (fcnt_r != '0);
  assign out_rgba  = fifo_mem[rd_ptr_r][55:24];
  assign out_x     = fifo_mem[rd_ptr_r][23:12];
  assign out_y     = fifo_mem[rd_ptr_r][11:0];

  always_ff @(posedge clk) begin
    if (fifo_wr) fifo_mem[wr_ptr_r] <= {res_rgba, bl_r.dx, bl_r.dy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      if (fifo_wr) wr_ptr_r <= wr_ptr_r + 5'd1;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 5'd1;
      fcnt_r <= fcnt_r + 6'(fifo_wr) - 6'(out_acc);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'(FIFO_DEPTH))
    else $error("outstanding result count exceeds queue depth");

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wr |-> (fcnt_r < 6'(FIFO_DEPTH)))
    else $error("result queue written while full");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= cnt_r)
    else $error("queued results exceed accepted computes");

  a_bubble_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_acc |=> !in_ready)
    else $error("transfer accepted in the cycle after a compute");

endmodule
